>>> src/disk_block_allocation_map_assert.svh
// ----------------------------------------------------------------------------
// Disk block allocation map - assertion macros
// Shared property templates for the allocation map's internal checks.
// ----------------------------------------------------------------------------
`ifndef DISK_BLOCK_ALLOCATION_MAP_ASSERT_SVH
`define DISK_BLOCK_ALLOCATION_MAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DBAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DBAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/dbam_pkg.sv
// ----------------------------------------------------------------------------
// Disk block allocation map - package
// Geometry constants, codes, map entry type and geometry helper functions.
// ----------------------------------------------------------------------------
package dbam_pkg;

    // Map geometry
    localparam int MAX_TRACKS  = 80;
    localparam int MAX_SECTORS = 40;
    localparam int IDX_W       = $clog2(MAX_TRACKS);
    localparam int BIT_IDX_W   = $clog2(MAX_SECTORS);

    // Field widths
    localparam int TRK_W = 7;
    localparam int SEC_W = 6;
    localparam int CNT_W = 6;
    localparam int TOT_W = 12;
    localparam int NUM_W = 7;   // sector count of a track, up to 40

    // Format codes
    localparam logic FMT_ZONED   = 1'b0;
    localparam logic FMT_UNIFORM = 1'b1;

    // Zoned geometry: one side of 35 tracks, zone ends and sector counts
    localparam logic [7:0] SIDE_TRACKS = 8'd35;
    localparam logic [7:0] ZONE1_END   = 8'd17;
    localparam logic [7:0] ZONE2_END   = 8'd24;
    localparam logic [7:0] ZONE3_END   = 8'd30;
    localparam logic [NUM_W-1:0] ZONE1_SECT = 7'd21;
    localparam logic [NUM_W-1:0] ZONE2_SECT = 7'd19;
    localparam logic [NUM_W-1:0] ZONE3_SECT = 7'd18;
    localparam logic [NUM_W-1:0] ZONE4_SECT = 7'd17;
    localparam logic [NUM_W-1:0] UNIFORM_SECT = 7'd40;

    // Directory tracks
    localparam logic [7:0] DIR_TRK_ZONED_A = 8'd18;
    localparam logic [7:0] DIR_TRK_ZONED_B = 8'd53;
    localparam logic [7:0] DIR_TRK_UNIFORM = 8'd40;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_QUERY   = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_INIT    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INIT,
        ST_INIT_DONE
    } state_t;

    // One map entry: free count and free-sector bitmap of a track
    typedef struct packed {
        logic [CNT_W-1:0]       count;
        logic [MAX_SECTORS-1:0] bitmap;
    } entry_t;

    // Sector count of a track in the given format, 0 if it does not exist
    function automatic logic [NUM_W-1:0] sectors_of(input logic fmt,
                                                    input logic [7:0] t);
        logic [7:0]       z;
        logic [NUM_W-1:0] n;
        n = '0;
        z = t;
        if (t == 8'd0 || t > 8'(MAX_TRACKS)) begin
            n = '0;
        end else if (fmt == FMT_ZONED) begin
            if (t > {SIDE_TRACKS[6:0], 1'b0}) begin
                n = '0;
            end else begin
                z = (t > SIDE_TRACKS) ? t - SIDE_TRACKS : t;
                if (z <= ZONE1_END)      n = ZONE1_SECT;
                else if (z <= ZONE2_END) n = ZONE2_SECT;
                else if (z <= ZONE3_END) n = ZONE3_SECT;
                else                     n = ZONE4_SECT;
            end
        end else begin
            n = UNIFORM_SECT;
        end
        if (n > NUM_W'(MAX_SECTORS)) n = NUM_W'(MAX_SECTORS);
        return n;
    endfunction

    // Directory tracks stay out of the disk total
    function automatic logic is_excluded(input logic fmt, input logic [7:0] t);
        if (fmt == FMT_ZONED) return (t == DIR_TRK_ZONED_A) || (t == DIR_TRK_ZONED_B);
        return t == DIR_TRK_UNIFORM;
    endfunction

    // Freshly formatted entry, with the system sectors already taken
    function automatic entry_t init_entry(input logic fmt, input logic [7:0] t);
        entry_t           e;
        logic [NUM_W-1:0] n;
        logic [NUM_W-1:0] taken;
        n = sectors_of(fmt, t);
        taken = '0;
        for (int i = 0; i < MAX_SECTORS; i++) begin
            e.bitmap[i] = (NUM_W'(i) < n);
        end
        if (n != '0) begin
            if (fmt == FMT_ZONED && t == DIR_TRK_ZONED_A) begin
                e.bitmap[1:0] = 2'b00;
                taken = 7'd2;
            end else if (fmt == FMT_ZONED && t == DIR_TRK_ZONED_B) begin
                e.bitmap[0] = 1'b0;
                taken = 7'd1;
            end else if (fmt == FMT_UNIFORM && t == DIR_TRK_UNIFORM) begin
                e.bitmap[3:0] = 4'b0000;
                taken = 7'd4;
            end
        end
        e.count = CNT_W'(n - taken);
        return e;
    endfunction

endpackage

>>> src/disk_block_allocation_map.sv
// ----------------------------------------------------------------------------
// Disk block allocation map
// Free-sector bitmap and per-track free counts of a two-format disk,
// kept in one synchronous map memory with read-modify-write access.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat on s_t*: action, track, sector. Output beat on m_t*: one
//   result per request (status, was_free, track_free, total_free).
//   cfg_wr_en/cfg_wr_data writes the format bit (0 zoned 70 tracks,
//   1 uniform 80 x 40); write it only while no request is in flight.
//   Query, allocate and release first read the track's map entry from
//   the registered memory read port, then modify it, write it back and
//   load the output register once that register is free.
//   Initialise sweeps the map one track per cycle, then loads its result
//   once the output register is free.
//   Reset clears the per-track valid flags, so every track reads as fully
//   allocated with count 0, the total reads 0 and the format is 1. No
//   clearing pass is needed; the block is ready right after reset.
//   A finished result sits in the output register; a new request is
//   accepted while it waits, but is not completed until the register is
//   free, so a stalled receiver holds the block after one more request.
// ----------------------------------------------------------------------------
module disk_block_allocation_map (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] action, [8:2] track, [14:9] sector
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] status, [2] was_free,
                                   // [8:3] track_free, [20:9] total_free
    // format register
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    // Request fields
    logic [1:0]                 in_action;
    logic [dbam_pkg::TRK_W-1:0] in_track;
    logic [dbam_pkg::SEC_W-1:0] in_sector;

    assign in_action = s_tdata[1:0];
    assign in_track  = s_tdata[8:2];
    assign in_sector = s_tdata[14:9];

    // State and registers
    dbam_pkg::state_t state_reg, state_next;
    logic                         fmt_reg;
    logic [1:0]                   act_reg;
    logic [dbam_pkg::TRK_W-1:0]   trk_reg;
    logic [dbam_pkg::SEC_W-1:0]   sec_reg;
    logic [dbam_pkg::TOT_W-1:0]   total_reg;
    logic [dbam_pkg::TOT_W-1:0]   sum_reg;
    logic [dbam_pkg::IDX_W-1:0]   init_idx_reg;
    logic [dbam_pkg::MAX_TRACKS-1:0] valid_reg;
    dbam_pkg::entry_t             rd_entry_reg;
    logic                         rd_vld_reg;
    logic                         m_tvalid_reg;
    logic [23:0]                  m_tdata_reg;

    // Map memory
    dbam_pkg::entry_t map_mem [dbam_pkg::MAX_TRACKS];

    // Control
    logic                       accept;
    logic                       out_free;
    logic                       rd_en;
    logic [dbam_pkg::IDX_W-1:0] rd_addr;
    logic                       mem_we;
    logic [dbam_pkg::IDX_W-1:0] wr_addr;
    dbam_pkg::entry_t           wr_data;
    logic                       load_exec;
    logic                       load_init;
    logic                       init_last;

    // Request datapath
    logic [dbam_pkg::NUM_W-1:0] req_n;
    dbam_pkg::entry_t           cur_entry;
    dbam_pkg::entry_t           new_entry;
    logic                       req_excl;
    logic                       req_wr;
    logic [1:0]                 res_status;
    logic                       res_wf;
    logic [dbam_pkg::CNT_W-1:0] res_tf;
    logic [dbam_pkg::TOT_W-1:0] tot_new;

    // Init sweep datapath
    logic [7:0]                 init_trk;
    dbam_pkg::entry_t           init_ent;
    dbam_pkg::entry_t           done_ent;
    logic [dbam_pkg::TOT_W:0]   sum_add;
    logic [dbam_pkg::TOT_W-1:0] sum_next;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign init_last = (init_idx_reg == dbam_pkg::IDX_W'(dbam_pkg::MAX_TRACKS - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dbam_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (in_action == dbam_pkg::ACT_INIT) ?
                                 dbam_pkg::ST_INIT : dbam_pkg::ST_EXEC;
                end
            end
            dbam_pkg::ST_EXEC: begin
                if (out_free) state_next = dbam_pkg::ST_IDLE;
            end
            dbam_pkg::ST_INIT: begin
                if (init_last) state_next = dbam_pkg::ST_INIT_DONE;
            end
            dbam_pkg::ST_INIT_DONE: begin
                if (out_free) state_next = dbam_pkg::ST_IDLE;
            end
            default: state_next = dbam_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs: handshake and memory control
    always_comb begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = dbam_pkg::IDX_W'(in_track - 7'd1);
        mem_we    = 1'b0;
        wr_addr   = dbam_pkg::IDX_W'(trk_reg - 7'd1);
        wr_data   = new_entry;
        load_exec = 1'b0;
        load_init = 1'b0;
        unique case (state_reg)
            dbam_pkg::ST_IDLE: begin
                s_tready = aresetn;
                rd_en    = s_tvalid && in_action != dbam_pkg::ACT_INIT &&
                           in_track != '0 &&
                           {1'b0, in_track} <= 8'(dbam_pkg::MAX_TRACKS);
            end
            dbam_pkg::ST_EXEC: begin
                load_exec = out_free;
                mem_we    = out_free && req_wr;
            end
            dbam_pkg::ST_INIT: begin
                mem_we  = 1'b1;
                wr_addr = init_idx_reg;
                wr_data = init_ent;
            end
            dbam_pkg::ST_INIT_DONE: begin
                load_init = out_free;
            end
            default: ;
        endcase
    end

    // Request: modify the entry read from the map
    always_comb begin
        req_n      = dbam_pkg::sectors_of(fmt_reg, {1'b0, trk_reg});
        cur_entry  = rd_vld_reg ? rd_entry_reg : '0;
        req_excl   = dbam_pkg::is_excluded(fmt_reg, {1'b0, trk_reg});
        new_entry  = cur_entry;
        req_wr     = 1'b0;
        res_status = dbam_pkg::STAT_DONE;
        res_wf     = 1'b0;
        res_tf     = '0;
        tot_new    = total_reg;
        if (req_n == '0) begin
            res_status = dbam_pkg::STAT_RANGE;
        end else if ({1'b0, sec_reg} >= req_n) begin
            res_status = dbam_pkg::STAT_RANGE;
            res_tf     = cur_entry.count;
        end else begin
            res_wf = cur_entry.bitmap[sec_reg[dbam_pkg::BIT_IDX_W-1:0]];
            case (act_reg)
                dbam_pkg::ACT_ALLOC: begin
                    if (res_wf) begin
                        new_entry.bitmap[sec_reg[dbam_pkg::BIT_IDX_W-1:0]] = 1'b0;
                        if (cur_entry.count != '0) new_entry.count = cur_entry.count - 1'b1;
                        if (!req_excl && total_reg != '0) tot_new = total_reg - 1'b1;
                        req_wr = 1'b1;
                    end else begin
                        res_status = dbam_pkg::STAT_REFUSED;
                    end
                end
                dbam_pkg::ACT_RELEASE: begin
                    if (!res_wf) begin
                        new_entry.bitmap[sec_reg[dbam_pkg::BIT_IDX_W-1:0]] = 1'b1;
                        if (cur_entry.count != dbam_pkg::CNT_MAX) begin
                            new_entry.count = cur_entry.count + 1'b1;
                        end
                        if (!req_excl && total_reg != dbam_pkg::TOT_MAX) begin
                            tot_new = total_reg + 1'b1;
                        end
                        req_wr = 1'b1;
                    end
                end
                default: ;
            endcase
            res_tf = new_entry.count;
        end
    end

    // Init sweep: fresh entry of the current track and running total
    always_comb begin
        init_trk = 8'(init_idx_reg) + 8'd1;
        init_ent = dbam_pkg::init_entry(fmt_reg, init_trk);
        done_ent = dbam_pkg::init_entry(fmt_reg, {1'b0, trk_reg});
        sum_add  = {1'b0, sum_reg};
        if (dbam_pkg::sectors_of(fmt_reg, init_trk) != '0 &&
            !dbam_pkg::is_excluded(fmt_reg, init_trk)) begin
            sum_add = {1'b0, sum_reg} + (dbam_pkg::TOT_W + 1)'(init_ent.count);
        end
        sum_next = sum_add[dbam_pkg::TOT_W] ? dbam_pkg::TOT_MAX :
                   sum_add[dbam_pkg::TOT_W-1:0];
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_entry_reg <= map_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dbam_pkg::ST_IDLE;
            fmt_reg      <= dbam_pkg::FMT_UNIFORM;
            valid_reg    <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) fmt_reg <= cfg_wr_data;
            if (mem_we) valid_reg[wr_addr] <= 1'b1;
            if (rd_en) rd_vld_reg <= valid_reg[rd_addr];
            if (load_exec) begin
                total_reg <= tot_new;
            end else if (state_reg == dbam_pkg::ST_INIT && init_last) begin
                total_reg <= sum_next;
            end
            if (load_exec || load_init) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request capture, sweep counter and output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg      <= in_action;
            trk_reg      <= in_track;
            sec_reg      <= in_sector;
            init_idx_reg <= '0;
            sum_reg      <= '0;
        end else if (state_reg == dbam_pkg::ST_INIT) begin
            init_idx_reg <= init_idx_reg + 1'b1;
            sum_reg      <= sum_next;
        end
        if (load_exec) begin
            m_tdata_reg <= {3'b000, tot_new, res_tf, res_wf, res_status};
        end else if (load_init) begin
            m_tdata_reg <= {3'b000, total_reg, done_ent.count, 1'b0, dbam_pkg::STAT_DONE};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
`include "disk_block_allocation_map_assert.svh"

    `DBAM_ASSERT_NOW(a_we_in_work, mem_we, (state_reg == dbam_pkg::ST_EXEC || state_reg == dbam_pkg::ST_INIT), "map write outside request or sweep")
    `DBAM_ASSERT_NEXT(a_accept_busy, accept, state_reg != dbam_pkg::ST_IDLE, "accepted beat left block idle")
    `DBAM_ASSERT_NOW(a_result_source, $rose(m_tvalid_reg), ($past(state_reg) == dbam_pkg::ST_EXEC || $past(state_reg) == dbam_pkg::ST_INIT_DONE), "result beat without a finished request")

endmodule
